/* rtl/lfn_pkg.sv */
// Shared types, constants and arithmetic helpers for the local frame unit.
package lfn_pkg;

  localparam int MAG_W      = 31;
  localparam int OUT_W      = 32;
  localparam int PROD_W     = 64;
  localparam int UNIT_FRAC  = 30;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  localparam logic [MAG_W-1:0] UNIT_ONE = MAG_W'(1) << UNIT_FRAC;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic [2:0] neg;
    mag_t [2:0] mag;
  } svec_t;

  typedef struct packed {
    logic v;
    logic degen;
  } ctl_t;

  typedef struct packed {
    logic [2:0][2:0][OUT_W-1:0] m;
    logic                       degen;
  } out_t;

  function automatic logic [PROD_W-1:0] smul(input logic na, input mag_t ma,
                                            input logic nb, input mag_t mb);
    logic [PROD_W-1:0] p;
    p = PROD_W'(ma) * PROD_W'(mb);
    return (na ^ nb) ? (~p + PROD_W'(1)) : p;
  endfunction

  function automatic logic [OUT_W-1:0] to_s32(input logic neg, input mag_t m);
    logic [OUT_W-1:0] v;
    v = {1'b0, m};
    return neg ? (~v + OUT_W'(1)) : v;
  endfunction

  function automatic logic [OUT_W-1:0] round_q60(input logic [PROD_W-1:0] d);
    logic [PROD_W-1:0] mg;
    logic [PROD_W-1:0] rs;
    mag_t              m;
    mg = d[PROD_W-1] ? (~d + PROD_W'(1)) : d;
    rs = (mg + (PROD_W'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC;
    m  = (rs > PROD_W'(UNIT_ONE)) ? UNIT_ONE : rs[MAG_W-1:0];
    return to_s32(d[PROD_W-1], m);
  endfunction

endpackage

/* rtl/lfn_reduce.sv */
// Power-of-two normalization of a three-component vector into sign and magnitude.
module lfn_reduce import lfn_pkg::*; #(
  parameter int IW = 33
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2:0][IW-1:0] in_c,
  output svec_t             out_r,
  output logic              zero_r
);

  localparam int PAD = (IW < MAG_W) ? MAG_W - IW : 0;
  localparam int LW  = IW + PAD;
  localparam int SW  = $clog2(LW);

  logic [2:0][IW-1:0] mag;
  logic [2:0][LW-1:0] ext;
  logic [2:0][LW-1:0] shifted;
  logic [LW-1:0]      any;
  logic [SW-1:0]      sh;
  svec_t              out_nxt;

  always_comb begin
    any = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = in_c[i][IW-1] ? (~in_c[i] + IW'(1)) : in_c[i];
      ext[i] = LW'(mag[i]) << PAD;
      any    = any | ext[i];
    end
    sh = '0;
    for (int b = 0; b < LW; b++) begin
      if (any[b]) sh = SW'(LW - 1 - b);
    end
    for (int i = 0; i < 3; i++) begin
      shifted[i]     = ext[i] << sh;
      out_nxt.mag[i] = shifted[i][LW-1 -: MAG_W];
      out_nxt.neg[i] = in_c[i][IW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r  <= out_nxt;
      zero_r <= ~|any;
    end
  end

endmodule

/* rtl/lfn_unit.sv */
// Two-lane unit-vector pipeline: squares, sum, 32-step square root, 31-step divide.
module lfn_unit import lfn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  ctl_t  in_ctl,
  input  svec_t in_x,
  input  svec_t in_z,
  output ctl_t  out_ctl,
  output svec_t out_x,
  output svec_t out_z
);

  localparam int LANES  = 2;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = PROD_W;
  localparam int ROOT_W = SUM_W / 2;
  localparam int NUM_W  = MAG_W + DIV_STEPS + 1;
  localparam int DEN_W  = ROOT_W + 1;

  svec_t [LANES-1:0] in_vec;

  ctl_t                           u1_ctl_r;
  svec_t [LANES-1:0]              u1_vec_r;
  logic  [LANES-1:0][2:0][SQ_W-1:0] u1_sq_r;

  ctl_t                       sq_ctl_r [0:SQRT_STEPS];
  svec_t [LANES-1:0]          sq_vec_r [0:SQRT_STEPS];
  logic  [LANES-1:0][SUM_W-1:0] sq_x_r [0:SQRT_STEPS];
  logic  [LANES-1:0][SUM_W-1:0] sq_q_r [0:SQRT_STEPS];

  logic [LANES-1:0][2:0][NUM_W-1:0] u3_num;

  ctl_t                              dv_ctl_r [0:DIV_STEPS];
  logic [LANES-1:0][2:0]             dv_neg_r [0:DIV_STEPS];
  logic [LANES-1:0][2:0][NUM_W-1:0]  dv_num_r [0:DIV_STEPS];
  logic [LANES-1:0][2:0][DEN_W-1:0]  dv_rem_r [0:DIV_STEPS];
  logic [LANES-1:0][2:0][MAG_W-1:0]  dv_q_r   [0:DIV_STEPS];
  logic [LANES-1:0][DEN_W-1:0]       dv_d_r   [0:DIV_STEPS];

  assign in_vec[0] = in_x;
  assign in_vec[1] = in_z;

  // squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_ctl_r <= '0;
    end else if (en) begin
      u1_ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_vec_r <= in_vec;
      for (int l = 0; l < LANES; l++) begin
        for (int i = 0; i < 3; i++) begin
          u1_sq_r[l][i] <= SQ_W'(in_vec[l].mag[i]) * SQ_W'(in_vec[l].mag[i]);
        end
      end
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctl_r[0] <= '0;
    end else if (en) begin
      sq_ctl_r[0] <= u1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_vec_r[0] <= u1_vec_r;
      for (int l = 0; l < LANES; l++) begin
        sq_x_r[0][l] <= SUM_W'(u1_sq_r[l][0]) + SUM_W'(u1_sq_r[l][1]) +
                        SUM_W'(u1_sq_r[l][2]);
        sq_q_r[0][l] <= '0;
      end
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] STEP_BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [LANES-1:0][SUM_W-1:0] t;
    logic [LANES-1:0][SUM_W-1:0] x_nxt;
    logic [LANES-1:0][SUM_W-1:0] q_nxt;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l] = sq_q_r[k][l] + STEP_BIT;
        if (sq_x_r[k][l] >= t[l]) begin
          x_nxt[l] = sq_x_r[k][l] - t[l];
          q_nxt[l] = (sq_q_r[k][l] >> 1) + STEP_BIT;
        end else begin
          x_nxt[l] = sq_x_r[k][l];
          q_nxt[l] = sq_q_r[k][l] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_ctl_r[k+1] <= '0;
      end else if (en) begin
        sq_ctl_r[k+1] <= sq_ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_vec_r[k+1] <= sq_vec_r[k];
        sq_x_r[k+1]   <= x_nxt;
        sq_q_r[k+1]   <= q_nxt;
      end
    end
  end

  // divide setup
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int i = 0; i < 3; i++) begin
        u3_num[l][i] = (NUM_W'(sq_vec_r[SQRT_STEPS][l].mag[i]) << DIV_STEPS) +
                       NUM_W'(sq_q_r[SQRT_STEPS][l][ROOT_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctl_r[0] <= '0;
    end else if (en) begin
      dv_ctl_r[0] <= sq_ctl_r[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        dv_d_r[0][l]   <= {sq_q_r[SQRT_STEPS][l][ROOT_W-1:0], 1'b0};
        dv_neg_r[0][l] <= sq_vec_r[SQRT_STEPS][l].neg;
        for (int i = 0; i < 3; i++) begin
          dv_num_r[0][l][i] <= u3_num[l][i];
          dv_rem_r[0][l][i] <= DEN_W'(u3_num[l][i][NUM_W-1:DIV_STEPS]);
          dv_q_r[0][l][i]   <= '0;
        end
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int NB = DIV_STEPS - 1 - j;
    logic [LANES-1:0][2:0][DEN_W:0]   rem2;
    logic [LANES-1:0][2:0][DEN_W-1:0] rem_nxt;
    logic [LANES-1:0][2:0][MAG_W-1:0] q_nxt;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        for (int i = 0; i < 3; i++) begin
          rem2[l][i] = {dv_rem_r[j][l][i], dv_num_r[j][l][i][NB]};
          if (rem2[l][i] >= {1'b0, dv_d_r[j][l]}) begin
            rem_nxt[l][i] = DEN_W'(rem2[l][i] - {1'b0, dv_d_r[j][l]});
            q_nxt[l][i]   = {dv_q_r[j][l][i][MAG_W-2:0], 1'b1};
          end else begin
            rem_nxt[l][i] = rem2[l][i][DEN_W-1:0];
            q_nxt[l][i]   = {dv_q_r[j][l][i][MAG_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_ctl_r[j+1] <= '0;
      end else if (en) begin
        dv_ctl_r[j+1] <= dv_ctl_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_d_r[j+1]   <= dv_d_r[j];
        dv_neg_r[j+1] <= dv_neg_r[j];
        dv_num_r[j+1] <= dv_num_r[j];
        dv_rem_r[j+1] <= rem_nxt;
        dv_q_r[j+1]   <= q_nxt;
      end
    end
  end

  assign out_ctl = dv_ctl_r[DIV_STEPS];
  assign out_x   = {dv_neg_r[DIV_STEPS][0], dv_q_r[DIV_STEPS][0]};
  assign out_z   = {dv_neg_r[DIV_STEPS][1], dv_q_r[DIV_STEPS][1]};

endmodule

/* rtl/lfn_yaxis.sv */
// Y axis from z cross x, Q2.30 rounding, and matrix or transpose selection.
module lfn_yaxis import lfn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  inverse,
  input  ctl_t  in_ctl,
  input  svec_t in_x,
  input  svec_t in_z,
  output logic  out_v,
  output out_t  out_word
);

  ctl_t                          y1_ctl_r;
  svec_t                         y1_x_r;
  svec_t                         y1_z_r;
  logic [5:0][PROD_W-1:0]        y1_prod_r;

  ctl_t                          y2_ctl_r;
  logic [2:0][2:0][OUT_W-1:0]    y2_mat_r;
  logic [2:0][2:0][OUT_W-1:0]    y2_mat_nxt;

  logic                          y3_v_r;
  out_t                          y3_word_r;
  out_t                          y3_word_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_ctl_r <= '0;
      y2_ctl_r <= '0;
      y3_v_r   <= 1'b0;
    end else if (en) begin
      y1_ctl_r <= in_ctl;
      y2_ctl_r <= y1_ctl_r;
      y3_v_r   <= y2_ctl_r.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1_x_r       <= in_x;
      y1_z_r       <= in_z;
      y1_prod_r[0] <= smul(in_z.neg[1], in_z.mag[1], in_x.neg[2], in_x.mag[2]);
      y1_prod_r[1] <= smul(in_z.neg[2], in_z.mag[2], in_x.neg[1], in_x.mag[1]);
      y1_prod_r[2] <= smul(in_z.neg[2], in_z.mag[2], in_x.neg[0], in_x.mag[0]);
      y1_prod_r[3] <= smul(in_z.neg[0], in_z.mag[0], in_x.neg[2], in_x.mag[2]);
      y1_prod_r[4] <= smul(in_z.neg[0], in_z.mag[0], in_x.neg[1], in_x.mag[1]);
      y1_prod_r[5] <= smul(in_z.neg[1], in_z.mag[1], in_x.neg[0], in_x.mag[0]);
      y2_mat_r     <= y2_mat_nxt;
      y3_word_r    <= y3_word_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y2_mat_nxt[0][i] = to_s32(y1_x_r.neg[i], y1_x_r.mag[i]);
      y2_mat_nxt[2][i] = to_s32(y1_z_r.neg[i], y1_z_r.mag[i]);
      y2_mat_nxt[1][i] = round_q60(y1_prod_r[2*i] - y1_prod_r[2*i+1]);
    end
  end

  always_comb begin
    y3_word_nxt.degen = y2_ctl_r.degen;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (y2_ctl_r.degen) begin
          y3_word_nxt.m[i][j] = '0;
        end else if (inverse) begin
          y3_word_nxt.m[i][j] = y2_mat_r[j][i];
        end else begin
          y3_word_nxt.m[i][j] = y2_mat_r[i][j];
        end
      end
    end
  end

  assign out_v    = y3_v_r;
  assign out_word = y3_word_r;

endmodule

/* rtl/local_frame_from_three_nodes_unit.sv */
// Top level: local orthonormal frame of a three-node element, fully pipelined.
//
//   port group   dir  handshake              payload
//   in_          in   in_valid / in_ready    p1..p3 x,y,z, COORD_WIDTH bits signed
//   out_         out  out_valid / out_ready  m00..m22 Q2.30, degenerate
//   cfg_         in   cfg_wr_en              cfg_wr_data -> output_inverse
//
// One word per cycle sustained while the skid entry stays empty; 75 register stages,
// set mostly by the 32-stage square root and 31-stage divide.
// Output register plus one skid entry; a full skid entry stalls the whole pipeline.
// rst_n is synchronous; it clears valid bits and output_inverse.
module local_frame_from_three_nodes_unit import lfn_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_p1_x,
  input  logic signed [COORD_WIDTH-1:0] in_p1_y,
  input  logic signed [COORD_WIDTH-1:0] in_p1_z,
  input  logic signed [COORD_WIDTH-1:0] in_p2_x,
  input  logic signed [COORD_WIDTH-1:0] in_p2_y,
  input  logic signed [COORD_WIDTH-1:0] in_p2_z,
  input  logic signed [COORD_WIDTH-1:0] in_p3_x,
  input  logic signed [COORD_WIDTH-1:0] in_p3_y,
  input  logic signed [COORD_WIDTH-1:0] in_p3_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       out_m00,
  output logic signed [OUT_W-1:0]       out_m01,
  output logic signed [OUT_W-1:0]       out_m02,
  output logic signed [OUT_W-1:0]       out_m10,
  output logic signed [OUT_W-1:0]       out_m11,
  output logic signed [OUT_W-1:0]       out_m12,
  output logic signed [OUT_W-1:0]       out_m20,
  output logic signed [OUT_W-1:0]       out_m21,
  output logic signed [OUT_W-1:0]       out_m22,
  output logic                          out_degenerate,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data
);

  localparam int EW = COORD_WIDTH + 1;

  logic                   adv;
  logic                   inv_r;

  logic                   v1_r;
  logic [2:0][EW-1:0]     e12_r;
  logic [2:0][EW-1:0]     e13_r;

  logic                   v2_r;
  svec_t                  a_r;
  svec_t                  b_r;
  logic                   za_r;
  logic                   zb_r;

  ctl_t                   ctl3_r;
  svec_t                  a3_r;
  logic [5:0][PROD_W-1:0] prod_r;

  ctl_t                   ctl4_r;
  svec_t                  a4_r;
  logic [2:0][PROD_W-1:0] c_r;

  ctl_t                   ctl5_r;
  svec_t                  a5_r;
  svec_t                  r_r;
  logic                   zc_r;

  ctl_t                   unit_in_ctl;
  ctl_t                   unit_ctl;
  svec_t                  unit_x;
  svec_t                  unit_z;

  logic                   up_v;
  out_t                   up_word;
  logic                   up_take;

  logic                   out_v_r;
  out_t                   out_r;
  logic                   skid_v_r;
  out_t                   skid_r;

  assign adv      = ~skid_v_r;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (cfg_wr_en) begin
      inv_r <= cfg_wr_data;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (adv) begin
      v1_r   <= in_valid;
      v2_r   <= v1_r;
      ctl3_r <= '{v: v2_r, degen: za_r | zb_r};
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  // edges, cross product, hold x source alongside
  always_ff @(posedge clk) begin
    if (adv) begin
      e12_r[0] <= {in_p2_x[COORD_WIDTH-1], in_p2_x} - {in_p1_x[COORD_WIDTH-1], in_p1_x};
      e12_r[1] <= {in_p2_y[COORD_WIDTH-1], in_p2_y} - {in_p1_y[COORD_WIDTH-1], in_p1_y};
      e12_r[2] <= {in_p2_z[COORD_WIDTH-1], in_p2_z} - {in_p1_z[COORD_WIDTH-1], in_p1_z};
      e13_r[0] <= {in_p3_x[COORD_WIDTH-1], in_p3_x} - {in_p1_x[COORD_WIDTH-1], in_p1_x};
      e13_r[1] <= {in_p3_y[COORD_WIDTH-1], in_p3_y} - {in_p1_y[COORD_WIDTH-1], in_p1_y};
      e13_r[2] <= {in_p3_z[COORD_WIDTH-1], in_p3_z} - {in_p1_z[COORD_WIDTH-1], in_p1_z};

      prod_r[0] <= smul(a_r.neg[1], a_r.mag[1], b_r.neg[2], b_r.mag[2]);
      prod_r[1] <= smul(a_r.neg[2], a_r.mag[2], b_r.neg[1], b_r.mag[1]);
      prod_r[2] <= smul(a_r.neg[2], a_r.mag[2], b_r.neg[0], b_r.mag[0]);
      prod_r[3] <= smul(a_r.neg[0], a_r.mag[0], b_r.neg[2], b_r.mag[2]);
      prod_r[4] <= smul(a_r.neg[0], a_r.mag[0], b_r.neg[1], b_r.mag[1]);
      prod_r[5] <= smul(a_r.neg[1], a_r.mag[1], b_r.neg[0], b_r.mag[0]);
      a3_r      <= a_r;

      c_r[0] <= prod_r[0] - prod_r[1];
      c_r[1] <= prod_r[2] - prod_r[3];
      c_r[2] <= prod_r[4] - prod_r[5];
      a4_r   <= a3_r;

      a5_r <= a4_r;
    end
  end

  lfn_reduce #(.IW(EW)) u_red_e12 (
    .clk    (clk),
    .en     (adv),
    .in_c   (e12_r),
    .out_r  (a_r),
    .zero_r (za_r)
  );

  lfn_reduce #(.IW(EW)) u_red_e13 (
    .clk    (clk),
    .en     (adv),
    .in_c   (e13_r),
    .out_r  (b_r),
    .zero_r (zb_r)
  );

  lfn_reduce #(.IW(PROD_W)) u_red_c (
    .clk    (clk),
    .en     (adv),
    .in_c   (c_r),
    .out_r  (r_r),
    .zero_r (zc_r)
  );

  assign unit_in_ctl = '{v: ctl5_r.v, degen: ctl5_r.degen | zc_r};

  lfn_unit u_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_ctl  (unit_in_ctl),
    .in_x    (a5_r),
    .in_z    (r_r),
    .out_ctl (unit_ctl),
    .out_x   (unit_x),
    .out_z   (unit_z)
  );

  lfn_yaxis u_yaxis (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .inverse  (inv_r),
    .in_ctl   (unit_ctl),
    .in_x     (unit_x),
    .in_z     (unit_z),
    .out_v    (up_v),
    .out_word (up_word)
  );

  // output register with one skid entry
  assign up_take = up_v & adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= up_take;
      end
    end else if (up_take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_r <= skid_v_r ? skid_r : up_word;
    end else if (up_take) begin
      skid_r <= up_word;
    end
  end

  assign out_valid      = out_v_r;
  assign out_m00        = out_r.m[0][0];
  assign out_m01        = out_r.m[0][1];
  assign out_m02        = out_r.m[0][2];
  assign out_m10        = out_r.m[1][0];
  assign out_m11        = out_r.m[1][1];
  assign out_m12        = out_r.m[1][2];
  assign out_m20        = out_r.m[2][0];
  assign out_m21        = out_r.m[2][1];
  assign out_m22        = out_r.m[2][2];
  assign out_degenerate = out_r.degen;

endmodule

/* tb/tb_local_frame_from_three_nodes_unit.sv */
// Testbench for the local frame unit: random and corner elements checked against a frame predictor.
`timescale 1ns / 1ps

module tb_local_frame_from_three_nodes_unit;
  import lfn_pkg::*;

  typedef struct packed {
    logic [8:0][31:0] p;
  } elem_t;

  typedef struct packed {
    logic [8:0][31:0] m;
    logic             degen;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_p [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_m [9];
  logic out_degenerate;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  elem_t  pending_elems[$];
  frame_t expected_frames[$];
  logic   inverse_mode = 1'b0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_send = 1'b0;
  bit     in_taken = 1'b0;
  int     mismatches = 0;
  longint cycle_count = 0;

  initial begin
    for (int i = 0; i < 9; i++) in_p[i] = '0;
  end

  always #10 clk = ~clk;

  local_frame_from_three_nodes_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_p1_x(in_p[0]), .in_p1_y(in_p[1]), .in_p1_z(in_p[2]),
    .in_p2_x(in_p[3]), .in_p2_y(in_p[4]), .in_p2_z(in_p[5]),
    .in_p3_x(in_p[6]), .in_p3_y(in_p[7]), .in_p3_z(in_p[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_m00(out_m[0]), .out_m01(out_m[1]), .out_m02(out_m[2]),
    .out_m10(out_m[3]), .out_m11(out_m[4]), .out_m12(out_m[5]),
    .out_m20(out_m[6]), .out_m21(out_m[7]), .out_m22(out_m[8]),
    .out_degenerate(out_degenerate),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit scale_vec(input longint v[3], output longint r[3]);
    logic [63:0] m[3];
    logic [63:0] top;
    int rs, ls;
    top = 0; rs = 0; ls = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(v[i]);
      if (m[i] > top) top = m[i];
    end
    for (int i = 0; i < 3; i++) r[i] = 0;
    if (top == 0) return 1'b0;
    while ((top >> rs) >= (64'd1 << 31)) rs++;
    while ((top << ls) < (64'd1 << 30)) ls++;
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'((m[i] >> rs) << ls);
      if (v[i] < 0) r[i] = -r[i];
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0; b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint r[3];
    logic [63:0] s, n, m;
    s = 0;
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (!scale_vec(v, r)) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      m = mag64(r[i]);
      s += m * m;
    end
    n = root64(s);
    for (int i = 0; i < 3; i++) begin
      m = mag64(r[i]);
      u[i] = longint'(((m << 31) + n) / (2 * n));
      if (r[i] < 0) u[i] = -u[i];
    end
    return 1'b1;
  endfunction

  function automatic longint round_to_q30(input longint d);
    logic [63:0] m;
    m = (mag64(d) + (64'd1 << 29)) >> 30;
    if (m > (64'd1 << 30)) m = 64'd1 << 30;
    return d < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic frame_t predict_frame(input elem_t e, input logic inv);
    frame_t f;
    longint p[9], e12[3], e13[3], a[3], b[3], c[3], fx[3], fy[3], fz[3];
    longint rows[3][3];
    bit ok;
    for (int i = 0; i < 9; i++) p[i] = longint'($signed(e.p[i]));
    for (int i = 0; i < 3; i++) begin
      e12[i] = p[3+i] - p[i];
      e13[i] = p[6+i] - p[i];
      fy[i] = 0; fz[i] = 0;
    end
    ok = unit_vec(e12, fx);
    if (ok) begin
      void'(scale_vec(e12, a));
      ok = scale_vec(e13, b);
    end
    if (ok) begin
      c[0] = a[1]*b[2] - a[2]*b[1];
      c[1] = a[2]*b[0] - a[0]*b[2];
      c[2] = a[0]*b[1] - a[1]*b[0];
      ok = unit_vec(c, fz);
    end
    if (ok) begin
      fy[0] = round_to_q30(fz[1]*fx[2] - fz[2]*fx[1]);
      fy[1] = round_to_q30(fz[2]*fx[0] - fz[0]*fx[2]);
      fy[2] = round_to_q30(fz[0]*fx[1] - fz[1]*fx[0]);
    end
    for (int j = 0; j < 3; j++) begin
      rows[0][j] = fx[j]; rows[1][j] = fy[j]; rows[2][j] = fz[j];
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        f.m[i*3+j] = !ok ? 32'd0 : 32'(inv ? rows[j][i] : rows[i][j]);
    f.degen = !ok;
    return f;
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_elems.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          elem_t e;
          e = pending_elems.pop_front();
          for (int i = 0; i < 9; i++) in_p[i] <= e.p[i];
          expected_frames.insert(expected_frames.size(), predict_frame(e, inverse_mode));
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_taken <= in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word at cycle %0d", cycle_count);
      end else begin
        frame_t x;
        bit bad;
        x = expected_frames.pop_front();
        bad = (x.degen != out_degenerate);
        for (int i = 0; i < 9; i++) if (x.m[i] !== out_m[i]) bad = 1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d: degenerate exp %0b got %0b", cycle_count,
                     x.degen, out_degenerate);
            for (int i = 0; i < 9; i++)
              $display("  m%0d%0d exp %0d got %0d", i/3, i%3, $signed(x.m[i]), out_m[i]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("[local_frame_from_three_nodes_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord(input int style);
    case (style)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  function automatic elem_t rand_elem();
    elem_t e;
    int style, kind;
    style = $urandom_range(3);
    kind = $urandom_range(19);
    for (int i = 0; i < 9; i++) e.p[i] = rand_coord(style);
    if (kind == 0) begin
      for (int i = 0; i < 3; i++) e.p[3+i] = e.p[i];
    end else if (kind == 1) begin
      for (int i = 0; i < 3; i++) e.p[6+i] = e.p[i] + 2 * (e.p[3+i] - e.p[i]);
    end else if (kind == 2) begin
      for (int i = 0; i < 3; i++) e.p[6+i] = e.p[i];
    end
    return e;
  endfunction

  task automatic drain_and_settle();
    while (pending_elems.size() > 0 || in_valid || expected_frames.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    inverse_mode = v;
  endtask

  task automatic add_elem(input logic [31:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
    elem_t e;
    e.p = {c2, c1, c0, b2, b1, b0, a2, a1, a0};
    pending_elems.insert(pending_elems.size(), e);
  endtask

  localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [31:0] MINC = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_elem(0, 0, 0, ONE, 0, 0, 0, ONE, 0);
    add_elem(0, 0, 0, 0, 0, 0, 0, ONE, 0);
    add_elem(0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0);
    add_elem(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
    add_elem(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MAXC);
    add_elem(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC, MINC);
    add_elem(MINC, 0, 0, MAXC, 0, 0, MINC, MAXC, 0);
    add_elem(0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_elem(0, 0, 0, 1, 1, 1, 1, 0, 0);
    add_elem(0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0);
    add_elem(5, 7, 9, 5, 8, 9, 6, 7, 11);
    add_elem(0, 0, 0, 3, 4, 0, 0, 0, 5);
    add_elem(0, 0, 0, MAXC, 1, 0, MAXC, 2, 0);
    add_elem(0, 0, 0, MAXC, MAXC, MAXC, 1, 0, 0);
    drain_and_settle();
    write_mode(1'b1);
    add_elem(0, 0, 0, 3, 4, 0, 0, 0, 5);
    add_elem(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MAXC);
    add_elem(0, 0, 0, 0, 0, 0, 0, ONE, 0);
    add_elem(5, 7, 9, 5, 8, 9, 6, 7, 11);
    drain_and_settle();

    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph[0]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 78; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 78; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int k = 0; k < 105; k++) begin
        pending_elems.insert(pending_elems.size(), rand_elem());
        if (ph == 2 && k == 50) begin
          while (pending_elems.size() > 0 || in_valid) @(posedge clk);
          hold_send = 1'b1;
          while (expected_frames.size() > 0) @(posedge clk);
          hold_send = 1'b0;
        end
      end
      drain_and_settle();
    end

    if (mismatches == 0) begin
      $display("[local_frame_from_three_nodes_unit] OK");
    end else begin
      $display("[local_frame_from_three_nodes_unit] ERROR");
    end
    $finish;
  end

endmodule
